>>> hw/rtl/iss_pkg.sv
// Shared types, codes and widths for the injection step sequencer.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package iss_pkg;

    localparam int WidthW    = 24;
    localparam int PhaseW    = 16;
    localparam int PressW    = 16;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 24;
    localparam int STdataW   = 16;
    localparam int STuserW   = 3;
    localparam int MTdataW   = 72;
    localparam int QDepth    = 2;
    localparam int QPtrW     = 1;
    localparam int QCntW     = 2;

    // Opcode of an input word
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Reason a run ended
    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_LIMIT  = 2'd1,
        CAUSE_SAFETY = 2'd2,
        CAUSE_TARGET = 2'd3
    } t_cause;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_START_WIDTH  = 3'd0,
        REG_TARGET_WIDTH = 3'd1,
        REG_STEP_LIMIT   = 3'd2,
        REG_RAMP_PERIOD  = 3'd3,
        REG_RAMP_DEC     = 3'd4,
        REG_PRESS_PERIOD = 3'd5,
        REG_SAFETY_PRESS = 3'd6,
        REG_TARGET_PRESS = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [WidthW-1:0] start_pulse_width;
        logic [WidthW-1:0] target_pulse_width;
        logic [WidthW-1:0] step_limit;
        logic [PhaseW-1:0] ramp_period;
        logic [WidthW-1:0] ramp_decrement;
        logic [PhaseW-1:0] pressure_period;
        logic [PressW-1:0] safety_pressure;
        logic [PressW-1:0] target_pressure;
    } t_cfg;

    // Classified command word passed from front end to back end
    typedef struct packed {
        t_cmd              cmd;
        logic              pressure_valid;
        logic [PressW-1:0] pressure;
    } t_cmd_word;

    typedef struct packed {
        logic              step_pulse;
        logic [WidthW-1:0] pulse_width;
        logic              motor_enable;
        t_cause            stop_cause;
        logic [WidthW-1:0] steps_done;
        logic [PressW-1:0] last_pressure;
    } t_result;

    localparam logic [WidthW-1:0] StartWidthRst  = 24'd2000;
    localparam logic [WidthW-1:0] TargetWidthRst = 24'd500;
    localparam logic [PressW-1:0] PressRst       = 16'hFFFF;

endpackage

>>> hw/rtl/iss_front.sv
// Front end: accepts input words, classifies the opcode and holds one command word.
// Depends on iss_pkg.
module iss_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_opcode,
    input  logic                        i_pressure_valid,
    input  logic [iss_pkg::PressW-1:0]  i_pressure,
    output logic                        o_push,
    input  logic                        i_push_ready,
    output iss_pkg::t_cmd_word          o_word
);

    logic               r_valid;
    iss_pkg::t_cmd_word r_word;
    iss_pkg::t_cmd_word n_word;
    logic               take;

    assign o_ready = !r_valid || i_push_ready;
    assign take    = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_word.pressure_valid = i_pressure_valid;
        n_word.pressure       = i_pressure;
        case (iss_pkg::t_cmd'(i_opcode))
            iss_pkg::CMD_START: n_word.cmd = iss_pkg::CMD_START;
            iss_pkg::CMD_STEP:  n_word.cmd = iss_pkg::CMD_STEP;
            iss_pkg::CMD_STOP:  n_word.cmd = iss_pkg::CMD_STOP;
            default:            n_word.cmd = iss_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

endmodule

>>> hw/rtl/iss_queue.sv
// Two-entry command queue between front end and back end.
// Depends on iss_pkg.
module iss_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_push_ready,
    input  iss_pkg::t_cmd_word i_word,
    output logic               o_valid,
    input  logic               i_pop,
    output iss_pkg::t_cmd_word o_word,
    output logic [iss_pkg::QCntW-1:0] o_count
);

    iss_pkg::t_cmd_word              r_mem [iss_pkg::QDepth];
    logic [iss_pkg::QPtrW-1:0]       r_wr_ptr;
    logic [iss_pkg::QPtrW-1:0]       r_rd_ptr;
    logic [iss_pkg::QCntW-1:0]       r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_push_ready = (r_count != iss_pkg::QCntW'(iss_pkg::QDepth));
    assign o_valid      = (r_count != '0);
    assign o_word       = r_mem[r_rd_ptr];
    assign o_count      = r_count;
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

>>> hw/rtl/iss_back.sv
// Back end: executes command words against the run state and registers one result word.
// Depends on iss_pkg.
module iss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iss_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  iss_pkg::t_cmd_word i_q_word,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output iss_pkg::t_result   o_result
);

    logic                          r_active, n_active;
    iss_pkg::t_cause               r_cause, n_cause;
    logic [iss_pkg::WidthW-1:0]    r_steps, n_steps;
    logic [iss_pkg::WidthW-1:0]    r_width, n_width;
    logic [iss_pkg::PhaseW-1:0]    r_ramp_ph, n_ramp_ph;
    logic [iss_pkg::PhaseW-1:0]    r_chk_ph, n_chk_ph;
    logic [iss_pkg::PressW-1:0]    r_seen, n_seen;
    logic                          r_out_valid;
    iss_pkg::t_result              r_out;
    iss_pkg::t_result              n_out;
    logic [iss_pkg::PhaseW-1:0]    ramp_next;
    logic [iss_pkg::PhaseW-1:0]    chk_next;
    logic [iss_pkg::WidthW:0]      floor_level;
    logic                          pulse;
    logic [iss_pkg::WidthW-1:0]    used_width;

    assign o_q_pop  = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign ramp_next   = r_ramp_ph + 1'b1;
    assign chk_next    = r_chk_ph + 1'b1;
    assign floor_level = {1'b0, i_cfg.target_pulse_width} + {1'b0, i_cfg.ramp_decrement};

    always_comb begin
        n_active   = r_active;
        n_cause    = r_cause;
        n_steps    = r_steps;
        n_width    = r_width;
        n_ramp_ph  = r_ramp_ph;
        n_chk_ph   = r_chk_ph;
        n_seen     = r_seen;
        pulse      = 1'b0;
        used_width = r_width;
        case (i_q_word.cmd)
            iss_pkg::CMD_START: begin
                n_active   = 1'b1;
                n_cause    = iss_pkg::CAUSE_NONE;
                n_steps    = '0;
                n_width    = i_cfg.start_pulse_width;
                n_ramp_ph  = '0;
                n_chk_ph   = '0;
                n_seen     = '0;
                used_width = i_cfg.start_pulse_width;
            end
            iss_pkg::CMD_STEP: begin
                if (r_active) begin
                    if (r_steps >= i_cfg.step_limit) begin
                        n_cause  = iss_pkg::CAUSE_LIMIT;
                        n_active = 1'b0;
                    end else begin
                        pulse   = 1'b1;
                        n_steps = r_steps + 1'b1;
                        if (i_cfg.ramp_period != '0) begin
                            if (ramp_next >= i_cfg.ramp_period) begin
                                n_ramp_ph = '0;
                                if ({1'b0, r_width} > floor_level) begin
                                    n_width = r_width - i_cfg.ramp_decrement;
                                end else begin
                                    n_width = i_cfg.target_pulse_width;
                                end
                            end else begin
                                n_ramp_ph = ramp_next;
                            end
                        end
                        if (i_cfg.pressure_period != '0) begin
                            if (chk_next >= i_cfg.pressure_period) begin
                                n_chk_ph = '0;
                                if (i_q_word.pressure_valid) begin
                                    n_seen = i_q_word.pressure;
                                    if (i_q_word.pressure >= i_cfg.safety_pressure) begin
                                        n_cause  = iss_pkg::CAUSE_SAFETY;
                                        n_active = 1'b0;
                                    end else if (i_q_word.pressure >= i_cfg.target_pressure) begin
                                        n_cause  = iss_pkg::CAUSE_TARGET;
                                        n_active = 1'b0;
                                    end
                                end
                            end else begin
                                n_chk_ph = chk_next;
                            end
                        end
                    end
                end
            end
            iss_pkg::CMD_STOP: begin
                if (r_active) begin
                    n_active = 1'b0;
                    n_cause  = iss_pkg::CAUSE_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.step_pulse    = pulse;
        n_out.pulse_width   = used_width;
        n_out.motor_enable  = n_active;
        n_out.stop_cause    = n_cause;
        n_out.steps_done    = n_steps;
        n_out.last_pressure = n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cause     <= iss_pkg::CAUSE_NONE;
            r_steps     <= '0;
            r_width     <= '0;
            r_ramp_ph   <= '0;
            r_chk_ph    <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_active  <= n_active;
                r_cause   <= n_cause;
                r_steps   <= n_steps;
                r_width   <= n_width;
                r_ramp_ph <= n_ramp_ph;
                r_chk_ph  <= n_chk_ph;
                r_seen    <= n_seen;
            end
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/injection_step_sequencer.sv
// Injection step sequencer top level: config registers, front end, queue, back end.
// Depends on iss_pkg, iss_front, iss_queue and iss_back.
// Path: an accepted input word passes through the front register, a queue entry and the
// back-end result register before its result word shows valid; result stalls delay it.
// Throughput: one word per cycle unless results stall; the back end updates the run state on every pop.
// Reset (synchronous, active low) ends any run, empties the queue, zeroes the run state
// and loads the config registers with their documented defaults.
module injection_step_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [iss_pkg::STdataW-1:0]   i_s_tdata,  // [15:0] pressure
    input  logic [iss_pkg::STuserW-1:0]   i_s_tuser,  // [1:0] opcode, [2] pressure_valid
    // Result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] step_pulse, [24:1] pulse_width, [25] motor_enable, [27:26] stop_cause,
    // [51:28] steps_done, [67:52] last_pressure, [71:68] zero
    output logic [iss_pkg::MTdataW-1:0]   o_m_tdata,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [iss_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [iss_pkg::CfgDataW-1:0]  i_cfg_data
);

    iss_pkg::t_cfg                r_cfg;
    iss_pkg::t_cmd_word           front_word;
    iss_pkg::t_cmd_word           q_word;
    iss_pkg::t_result             result;
    logic                         front_push;
    logic                         q_push_ready;
    logic                         q_valid;
    logic                         q_pop;
    logic [iss_pkg::QCntW-1:0]    q_count;
    logic                         cfg_we;

    // Hold off config writes while a command word sits in the front register or queue.
    assign o_cfg_ready = !front_push && (q_count == '0);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_pulse_width  <= iss_pkg::StartWidthRst;
            r_cfg.target_pulse_width <= iss_pkg::TargetWidthRst;
            r_cfg.step_limit         <= '0;
            r_cfg.ramp_period        <= '0;
            r_cfg.ramp_decrement     <= '0;
            r_cfg.pressure_period    <= '0;
            r_cfg.safety_pressure    <= iss_pkg::PressRst;
            r_cfg.target_pressure    <= iss_pkg::PressRst;
        end else if (cfg_we) begin
            case (iss_pkg::t_cfg_idx'(i_cfg_index))
                iss_pkg::REG_START_WIDTH:  r_cfg.start_pulse_width  <= i_cfg_data;
                iss_pkg::REG_TARGET_WIDTH: r_cfg.target_pulse_width <= i_cfg_data;
                iss_pkg::REG_STEP_LIMIT:   r_cfg.step_limit         <= i_cfg_data;
                iss_pkg::REG_RAMP_PERIOD:  r_cfg.ramp_period        <= i_cfg_data[15:0];
                iss_pkg::REG_RAMP_DEC:     r_cfg.ramp_decrement     <= i_cfg_data;
                iss_pkg::REG_PRESS_PERIOD: r_cfg.pressure_period    <= i_cfg_data[15:0];
                iss_pkg::REG_SAFETY_PRESS: r_cfg.safety_pressure    <= i_cfg_data[15:0];
                iss_pkg::REG_TARGET_PRESS: r_cfg.target_pressure    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: take a word, decode the opcode, hold it until the queue has room.
    iss_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_opcode         (i_s_tuser[1:0]),
        .i_pressure_valid (i_s_tuser[2]),
        .i_pressure       (i_s_tdata),
        .o_push           (front_push),
        .i_push_ready     (q_push_ready),
        .o_word           (front_word)
    );

    // Queue: decouple a stalled result side from the command side.
    iss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (q_push_ready),
        .i_word       (front_word),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_word       (q_word),
        .o_count      (q_count)
    );

    // Back end: advance the run state and register the result word.
    iss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_word  (q_word),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (result)
    );

    // Pack fields from bit 0 up; pad the top nibble with zeros.
    assign o_m_tdata = {4'd0,
                        result.last_pressure,
                        result.steps_done,
                        result.stop_cause,
                        result.motor_enable,
                        result.pulse_width,
                        result.step_pulse};

    // A stop reason is only ever reported with the motor off.
    a_cause_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (result.stop_cause != iss_pkg::CAUSE_NONE) |-> !result.motor_enable)
        else $error("stop cause reported while motor enabled");

    // An issued step is always counted, so the count cannot read zero.
    a_step_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && result.step_pulse |-> (result.steps_done != '0))
        else $error("step issued with zero step count");

    // The queue never holds more words than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= iss_pkg::QCntW'(iss_pkg::QDepth))
        else $error("command queue overfilled");

    // A pop is only taken when the result register is free or being drained.
    a_pop_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!o_m_tvalid || i_m_tready))
        else $error("result word overwritten before delivery");

endmodule
